>>> hw/rtl/rtp_seq_pkg.sv
`default_nettype none

package rtp_seq_pkg;

	// field widths
	localparam int SEQ_W   = 16;
	localparam int CNT_W   = 32;
	localparam int FRAC_W  = 8;
	localparam int LIMIT_W = 8;
	localparam int WIN_W   = 15;

	// bus widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 144;
	localparam int OUT_USED_W = 137;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// divider steps: one quotient bit per cycle
	localparam int DIV_STEPS = CNT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// register word index (paddr[2])
	localparam logic REG_FAIL_LIMIT     = 1'b0;
	localparam logic REG_REORDER_WINDOW = 1'b1;

	// reset values
	localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST = 8'd8;
	localparam logic [WIN_W-1:0]   WINDOW_RST     = 15'd64;

	// request kinds
	localparam logic FUNC_ARRIVAL = 1'b0;
	localparam logic FUNC_PLAYOUT = 1'b1;

	typedef struct packed {
		logic [LIMIT_W-1:0] fail_limit;
		logic [WIN_W-1:0]   reorder_window;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FRAC_W-1:0] quot;
	} div_rsp_t;

	// nxt below cur, modulo 2^16, inside window w
	function automatic logic seq_lower(input logic [SEQ_W-1:0] cur,
			input logic [SEQ_W-1:0] nxt, input logic [WIN_W-1:0] w);
		logic [SEQ_W-1:0] wx;
		logic [SEQ_W-1:0] cs;
		logic [SEQ_W-1:0] ns;
		wx = {1'b0, w};
		cs = cur + wx;
		ns = nxt + wx;
		if (cur > wx) begin
			return nxt < cur;
		end
		return ns < cs;
	endfunction

	// nxt above cur, modulo 2^16, inside window w
	function automatic logic seq_higher(input logic [SEQ_W-1:0] cur,
			input logic [SEQ_W-1:0] nxt, input logic [WIN_W-1:0] w);
		logic [SEQ_W-1:0] wx;
		logic [SEQ_W-1:0] thr;
		logic [SEQ_W-1:0] cs;
		logic [SEQ_W-1:0] ns;
		wx  = {1'b0, w};
		thr = SEQ_W'(0) - wx;
		cs  = cur + wx;
		ns  = nxt + wx;
		if (cur < thr) begin
			return nxt > cur;
		end
		return ns > cs;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rtp_seq_regs.sv
`default_nettype none

module rtp_seq_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [rtp_seq_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [rtp_seq_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [rtp_seq_pkg::APB_DATA_W-1:0] prdata,
	output logic                                     pready,
	output rtp_seq_pkg::cfg_t                        cfg
);

	rtp_seq_pkg::cfg_t cfg_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes; byte offset bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fail_limit     <= rtp_seq_pkg::FAIL_LIMIT_RST;
			cfg_q.reorder_window <= rtp_seq_pkg::WINDOW_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				rtp_seq_pkg::REG_FAIL_LIMIT: begin
					cfg_q.fail_limit <= pwdata[rtp_seq_pkg::LIMIT_W-1:0];
				end
				rtp_seq_pkg::REG_REORDER_WINDOW: begin
					cfg_q.reorder_window <= pwdata[rtp_seq_pkg::WIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			rtp_seq_pkg::REG_FAIL_LIMIT: begin
				prdata = rtp_seq_pkg::APB_DATA_W'(cfg_q.fail_limit);
			end
			rtp_seq_pkg::REG_REORDER_WINDOW: begin
				prdata = rtp_seq_pkg::APB_DATA_W'(cfg_q.reorder_window);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/rtp_seq_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Dividend shifts out at the top while quotient bits shift in at the bottom.
module rtp_seq_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rtp_seq_pkg::div_req_t req,
	output rtp_seq_pkg::div_rsp_t      rsp
);

	logic                               busy_q;
	logic                               done_q;
	logic [rtp_seq_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [rtp_seq_pkg::CNT_W-1:0]     rem_q;
	logic [rtp_seq_pkg::CNT_W-1:0]     dvd_q;
	logic [rtp_seq_pkg::CNT_W-1:0]     dsr_q;

	logic [rtp_seq_pkg::CNT_W:0]       trial;
	logic                               fits;
	logic [rtp_seq_pkg::CNT_W:0]       diff;

	// one trial subtract per step
	always_comb begin
		trial = {rem_q, dvd_q[rtp_seq_pkg::CNT_W-1]};
		fits  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= rtp_seq_pkg::DIV_CNT_W'(rtp_seq_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[rtp_seq_pkg::CNT_W-1:0] : trial[rtp_seq_pkg::CNT_W-1:0];
			dvd_q <= {dvd_q[rtp_seq_pkg::CNT_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q[rtp_seq_pkg::FRAC_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/rtp_receive_sequence_tracker.sv
// Channel    Dir  Signals                       Contents
// s_axis     in   tvalid/tready/tdata/tuser     one request: arrival or playout
// m_axis     out  tvalid/tready/tdata           one result per request
// apb        in   psel/penable/pwrite/paddr...  fail_limit @0x0, reorder_window @0x4
//
// Arrival, playout hit or miss before any packet: update, then load output register.
// Playout miss with packets received: waits on the bit-serial
// 32-step restoring divider that forms the lost fraction.
// Reset clears all tracking state; registers return to 8 and 64.
// A result waiting on m_axis does not block the next request; a request
// stalls while the previous request is dividing or waiting for the output register.
`default_nettype none

module rtp_receive_sequence_tracker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// tdata: [15:0] seq, [16] found, [23:17] zero
	input  wire logic [rtp_seq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: [0] func
	input  wire logic                                s_axis_tuser,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// tdata: [15:0] expected_seq, [31:16] highest_seq, [63:32] ext_seq,
	// [95:64] received_count, [127:96] lost_count, [135:128] lost_fraction,
	// [136] missed, [143:137] zero
	output logic      [rtp_seq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [rtp_seq_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [rtp_seq_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [rtp_seq_pkg::APB_DATA_W-1:0] prdata,
	output logic                                     pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	rtp_seq_pkg::cfg_t     cfg;
	rtp_seq_pkg::div_req_t div_req;
	rtp_seq_pkg::div_rsp_t div_rsp;

	logic [1:0]                          state_q;
	logic [rtp_seq_pkg::SEQ_W-1:0]      low_seq_q;
	logic [rtp_seq_pkg::SEQ_W-1:0]      high_seq_q;
	logic [rtp_seq_pkg::LIMIT_W-1:0]    miss_run_q;
	logic [rtp_seq_pkg::CNT_W-1:0]      rx_total_q;
	logic [rtp_seq_pkg::CNT_W-1:0]      loss_total_q;
	logic [rtp_seq_pkg::FRAC_W-1:0]     loss_frac_q;
	logic [rtp_seq_pkg::SEQ_W-1:0]      wrap_count_q;
	logic [rtp_seq_pkg::CNT_W-1:0]      last_ext_q;
	logic                                missed_q;
	logic                                out_valid_q;
	logic [rtp_seq_pkg::OUT_USED_W-1:0] out_data_q;

	logic                                s_fire;
	logic                                in_func;
	logic [rtp_seq_pkg::SEQ_W-1:0]      in_seq;
	logic                                in_found;
	logic                                resync;
	logic                                take_low;
	logic                                take_high;
	logic [rtp_seq_pkg::SEQ_W-1:0]      low_inc;
	logic [rtp_seq_pkg::CNT_W-1:0]      loss_inc;
	logic                                out_free;

	rtp_seq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtp_seq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_func  = s_axis_tuser;
	assign in_seq   = s_axis_tdata[rtp_seq_pkg::SEQ_W-1:0];
	assign in_found = s_axis_tdata[rtp_seq_pkg::SEQ_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// arrival decisions
	always_comb begin
		resync    = miss_run_q >= cfg.fail_limit;
		take_low  = (low_seq_q == '0)
			|| rtp_seq_pkg::seq_lower(low_seq_q, in_seq, cfg.reorder_window);
		take_high = rtp_seq_pkg::seq_higher(high_seq_q, in_seq, cfg.reorder_window);
		low_inc   = low_seq_q + 1'b1;
		loss_inc  = loss_total_q + 1'b1;
	end

	// lost fraction request: (256 * loss) mod 2^32 over received
	assign div_req.start    = s_fire && (in_func == rtp_seq_pkg::FUNC_PLAYOUT)
		&& !in_found && (rx_total_q != '0);
	assign div_req.dividend = {loss_inc[rtp_seq_pkg::CNT_W-rtp_seq_pkg::FRAC_W-1:0],
		rtp_seq_pkg::FRAC_W'(0)};
	assign div_req.divisor  = rx_total_q;

	// sequencer and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			low_seq_q    <= '0;
			high_seq_q   <= '0;
			miss_run_q   <= '0;
			rx_total_q   <= '0;
			loss_total_q <= '0;
			loss_frac_q  <= '0;
			wrap_count_q <= '0;
			last_ext_q   <= '0;
			missed_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_LOAD;
						if (in_func == rtp_seq_pkg::FUNC_ARRIVAL) begin
							missed_q <= 1'b0;
							if (resync) begin
								miss_run_q <= '0;
								low_seq_q  <= in_seq;
								high_seq_q <= in_seq;
							end else begin
								if (take_low) begin
									low_seq_q <= in_seq;
								end
								if (take_high) begin
									high_seq_q <= in_seq;
								end
							end
							rx_total_q <= rx_total_q + 1'b1;
							last_ext_q <= {wrap_count_q, in_seq};
						end else begin
							if (!in_found) begin
								missed_q     <= 1'b1;
								loss_total_q <= loss_inc;
								if (miss_run_q != '1) begin
									miss_run_q <= miss_run_q + 1'b1;
								end
								if (div_req.start) begin
									state_q <= ST_DIV;
								end
							end else begin
								missed_q   <= 1'b0;
								miss_run_q <= '0;
							end
							low_seq_q <= low_inc;
							if (low_inc == '0) begin
								wrap_count_q <= wrap_count_q + 1'b1;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						loss_frac_q <= div_rsp.quot;
						state_q     <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_LOAD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && out_free) begin
			out_data_q <= {missed_q, loss_frac_q, loss_total_q, rx_total_q,
				last_ext_q, high_seq_q, low_seq_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(rtp_seq_pkg::OUT_DATA_W - rtp_seq_pkg::OUT_USED_W)'(0),
		out_data_q};

	// divider finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider done outside divide wait");

	// an arrival counts exactly one packet
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && in_func == rtp_seq_pkg::FUNC_ARRIVAL)
		|=> rx_total_q == $past(rx_total_q) + 32'd1)
		else $error("received count not advanced on arrival");

	// a playout hit clears the miss run
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && in_func == rtp_seq_pkg::FUNC_PLAYOUT && in_found)
		|=> miss_run_q == '0)
		else $error("miss run not cleared on hit");

	// lost fraction moves only when a division completes
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(loss_frac_q) |-> $past(div_rsp.done))
		else $error("lost fraction changed without division");

endmodule

`default_nettype wire

>>> tb/sv/rtp_receive_sequence_tracker_test.sv
`default_nettype none

module rtp_receive_sequence_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                          func;
		logic [rtp_seq_pkg::SEQ_W-1:0] seq;
		logic                          found;
	} seq_req_t;

	typedef struct packed {
		logic [rtp_seq_pkg::SEQ_W-1:0]  expected_seq;
		logic [rtp_seq_pkg::SEQ_W-1:0]  highest_seq;
		logic [rtp_seq_pkg::CNT_W-1:0]  ext_seq;
		logic [rtp_seq_pkg::CNT_W-1:0]  received_count;
		logic [rtp_seq_pkg::CNT_W-1:0]  lost_count;
		logic [rtp_seq_pkg::FRAC_W-1:0] lost_fraction;
		logic                           missed;
	} track_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic [rtp_seq_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                               s_axis_tuser = 1'b0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [rtp_seq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b0;
	logic [rtp_seq_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [rtp_seq_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [rtp_seq_pkg::APB_DATA_W-1:0] prdata;
	logic                               pready;

	rtp_receive_sequence_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	// requests waiting for the driver, results waiting for the block
	seq_req_t      pending_reqs[$];
	track_result_t expected_results[$];
	int            issued_reqs = 0;
	int            accepted_reqs = 0;
	int            err_count = 0;
	bit            calm = 1'b0;
	int            hold_at = 32'h7fffffff;

	// shadow of the tracker: configuration and state
	logic [rtp_seq_pkg::LIMIT_W-1:0] cfg_fail_limit = rtp_seq_pkg::FAIL_LIMIT_RST;
	logic [rtp_seq_pkg::WIN_W-1:0]   cfg_window = rtp_seq_pkg::WINDOW_RST;
	logic [rtp_seq_pkg::SEQ_W-1:0]   trk_low = '0;
	logic [rtp_seq_pkg::SEQ_W-1:0]   trk_high = '0;
	logic [7:0]                      trk_miss_run = '0;
	logic [rtp_seq_pkg::CNT_W-1:0]   trk_rx_total = '0;
	logic [rtp_seq_pkg::CNT_W-1:0]   trk_loss_total = '0;
	logic [rtp_seq_pkg::FRAC_W-1:0]  trk_loss_frac = '0;
	logic [rtp_seq_pkg::SEQ_W-1:0]   trk_wraps = '0;
	logic [rtp_seq_pkg::CNT_W-1:0]   trk_last_ext = '0;

	logic [rtp_seq_pkg::SEQ_W-1:0] flow_seq = '0;

	task automatic report_err(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	// nxt is below cur inside the reorder window, modulo 2^16
	function automatic bit win_below(input logic [rtp_seq_pkg::SEQ_W-1:0] cur,
			input logic [rtp_seq_pkg::SEQ_W-1:0] nxt);
		logic [rtp_seq_pkg::SEQ_W-1:0] w;
		logic [rtp_seq_pkg::SEQ_W-1:0] cs;
		logic [rtp_seq_pkg::SEQ_W-1:0] ns;
		w = {1'b0, cfg_window};
		cs = cur + w;
		ns = nxt + w;
		if (cur > w) begin
			return nxt < cur;
		end
		return ns < cs;
	endfunction

	// nxt is above cur inside the reorder window, modulo 2^16
	function automatic bit win_above(input logic [rtp_seq_pkg::SEQ_W-1:0] cur,
			input logic [rtp_seq_pkg::SEQ_W-1:0] nxt);
		logic [rtp_seq_pkg::SEQ_W-1:0] w;
		logic [rtp_seq_pkg::SEQ_W-1:0] thr;
		logic [rtp_seq_pkg::SEQ_W-1:0] cs;
		logic [rtp_seq_pkg::SEQ_W-1:0] ns;
		w = {1'b0, cfg_window};
		thr = 16'h0000 - w;
		cs = cur + w;
		ns = nxt + w;
		if (cur < thr) begin
			return nxt > cur;
		end
		return ns > cs;
	endfunction

	// apply one request to the shadow state, return the reported result
	function automatic track_result_t track_request(input seq_req_t r);
		track_result_t res;
		logic [rtp_seq_pkg::CNT_W-1:0] scaled;
		res.missed = 1'b0;
		if (r.func == rtp_seq_pkg::FUNC_ARRIVAL) begin
			if (trk_miss_run >= cfg_fail_limit) begin
				trk_miss_run = '0;
				trk_low = r.seq;
				trk_high = r.seq;
			end else begin
				if (trk_low == 0 || win_below(trk_low, r.seq))
					trk_low = r.seq;
				if (win_above(trk_high, r.seq))
					trk_high = r.seq;
			end
			trk_rx_total = trk_rx_total + 1;
			trk_last_ext = {trk_wraps, r.seq};
		end else begin
			if (!r.found) begin
				res.missed = 1'b1;
				if (trk_miss_run != 8'hff)
					trk_miss_run = trk_miss_run + 1'b1;
				trk_loss_total = trk_loss_total + 1;
				if (trk_rx_total != 0) begin
					scaled = trk_loss_total << 8;
					trk_loss_frac = rtp_seq_pkg::FRAC_W'(scaled / trk_rx_total);
				end
			end else begin
				trk_miss_run = '0;
			end
			trk_low = trk_low + 1'b1;
			if (trk_low == 0)
				trk_wraps = trk_wraps + 1'b1;
		end
		res.expected_seq = trk_low;
		res.highest_seq = trk_high;
		res.ext_seq = trk_last_ext;
		res.received_count = trk_rx_total;
		res.lost_count = trk_loss_total;
		res.lost_fraction = trk_loss_frac;
		return res;
	endfunction

	// request driver: holds each request until taken, random gaps between
	always @(negedge clk) begin
		static int tx_gap = 0;
		seq_req_t nreq;
		if (arst_n && issued_reqs == accepted_reqs) begin
			if (tx_gap != 0) begin
				tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(7) == 0) begin
				tx_gap = $urandom_range(13);
				s_axis_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				nreq = pending_reqs.pop_front();
				s_axis_tdata <= {7'b0, nreq.found, nreq.seq};
				s_axis_tuser <= nreq.func;
				s_axis_tvalid <= 1'b1;
				issued_reqs++;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls, plus one long hold-off
	always @(negedge clk) begin
		static int rx_gap = 0;
		static int hold_left = 0;
		static bit hold_used = 1'b0;
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_used && accepted_reqs >= hold_at) begin
				hold_used = 1'b1;
				hold_left = 399;
				m_axis_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(9) == 0) begin
				rx_gap = $urandom_range(13);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor: predict on each accepted request, check each result
	always @(posedge clk) begin
		seq_req_t      req;
		track_result_t got;
		track_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				req.func = s_axis_tuser;
				req.seq = s_axis_tdata[15:0];
				req.found = s_axis_tdata[16];
				expected_results.push_back(track_request(req));
				accepted_reqs++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.expected_seq = m_axis_tdata[15:0];
				got.highest_seq = m_axis_tdata[31:16];
				got.ext_seq = m_axis_tdata[63:32];
				got.received_count = m_axis_tdata[95:64];
				got.lost_count = m_axis_tdata[127:96];
				got.lost_fraction = m_axis_tdata[135:128];
				got.missed = m_axis_tdata[136];
				if (expected_results.size() == 0) begin
					report_err($sformatf("result with no request pending: %h", m_axis_tdata));
				end else begin
					want = expected_results.pop_front();
					if (got.expected_seq !== want.expected_seq)
						report_err($sformatf("expected_seq %h, want %h",
							got.expected_seq, want.expected_seq));
					if (got.highest_seq !== want.highest_seq)
						report_err($sformatf("highest_seq %h, want %h",
							got.highest_seq, want.highest_seq));
					if (got.ext_seq !== want.ext_seq)
						report_err($sformatf("ext_seq %h, want %h", got.ext_seq, want.ext_seq));
					if (got.received_count !== want.received_count)
						report_err($sformatf("received_count %h, want %h",
							got.received_count, want.received_count));
					if (got.lost_count !== want.lost_count)
						report_err($sformatf("lost_count %h, want %h",
							got.lost_count, want.lost_count));
					if (got.lost_fraction !== want.lost_fraction)
						report_err($sformatf("lost_fraction %h, want %h",
							got.lost_fraction, want.lost_fraction));
					if (got.missed !== want.missed)
						report_err($sformatf("missed %b, want %b", got.missed, want.missed));
				end
			end
		end
	end

	task automatic push_req(input logic func, input logic [rtp_seq_pkg::SEQ_W-1:0] seq,
			input logic found);
		seq_req_t r;
		r.func = func;
		r.seq = seq;
		r.found = found;
		pending_reqs.push_back(r);
	endtask

	task automatic write_reg(input logic reg_idx,
			input logic [rtp_seq_pkg::APB_DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (reg_idx == rtp_seq_pkg::REG_FAIL_LIMIT)
			cfg_fail_limit = value[rtp_seq_pkg::LIMIT_W-1:0];
		else
			cfg_window = value[rtp_seq_pkg::WIN_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input int fail_limit, input int window);
		write_reg(rtp_seq_pkg::REG_FAIL_LIMIT, fail_limit);
		write_reg(rtp_seq_pkg::REG_REORDER_WINDOW, window);
	endtask

	// block is idle once every request has been taken and answered
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || issued_reqs != accepted_reqs ||
				expected_results.size() != 0)
			@(posedge clk);
	endtask

	// mostly an in-order stream with reordering and playout, plus outages and noise
	task automatic push_traffic(input int n);
		int made;
		int run;
		int k;
		made = 0;
		while (made < n) begin
			case ($urandom_range(19))
				0, 1: begin
					// outage: run of misses, then the stream restarts somewhere
					if (cfg_fail_limit > 12)
						run = $urandom_range(14, 1);
					else
						run = $urandom_range(cfg_fail_limit + 2, 1);
					for (k = 0; k < run; k++)
						push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'($urandom), 1'b0);
					if ($urandom_range(1))
						flow_seq = 16'hfff0 + 16'($urandom_range(15));
					else
						flow_seq = 16'($urandom);
					push_req(rtp_seq_pkg::FUNC_ARRIVAL, flow_seq, 1'($urandom));
					made += run + 1;
				end
				2: begin
					push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'($urandom), 1'($urandom));
					made++;
				end
				3: begin
					push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'($urandom), 1'($urandom));
					made++;
				end
				default: begin
					if ($urandom_range(1)) begin
						case ($urandom_range(7))
							0: push_req(rtp_seq_pkg::FUNC_ARRIVAL,
								flow_seq - 16'($urandom_range(8, 1)), 1'($urandom));
							1: push_req(rtp_seq_pkg::FUNC_ARRIVAL,
								flow_seq + 16'($urandom_range(200)), 1'($urandom));
							default: begin
								push_req(rtp_seq_pkg::FUNC_ARRIVAL, flow_seq, 1'($urandom));
								flow_seq = flow_seq + 1'b1;
							end
						endcase
					end else begin
						push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'($urandom),
							$urandom_range(5) != 0);
					end
					made++;
				end
			endcase
		end
	endtask

	initial begin
		int k;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset configuration
		push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'hffff, 1'b0);   // miss before any packet
		push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'h0000, 1'b1);
		push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'hffff, 1'b1);
		push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'h0000, 1'b0);
		push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'h8000, 1'b0);
		push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'h0001, 1'b1);
		push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'h0040, 1'b0);
		for (k = 0; k < 8; k++)
			push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'h5555, 1'b0);
		push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'hfffe, 1'b0);   // resync near the wrap
		push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'h0000, 1'b1);
		push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'haaaa, 1'b1);   // expected passes through zero
		push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'h0000, 1'b0);
		push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'h0005, 1'b1);
		push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'hffff, 1'b0);
		wait_idle();

		push_traffic(120);
		wait_idle();

		// widest settings, with a miss run long enough to saturate
		set_config(255, 32767);
		push_traffic(25);
		for (k = 0; k < 260; k++)
			push_req(rtp_seq_pkg::FUNC_PLAYOUT, 16'($urandom), 1'b0);
		push_req(rtp_seq_pkg::FUNC_ARRIVAL, 16'($urandom), 1'b0);
		push_traffic(25);
		wait_idle();

		set_config(1, 1);
		push_traffic(100);
		wait_idle();

		// zero limit resyncs on every arrival, zero window compares plainly
		set_config(0, 0);
		push_traffic(80);
		wait_idle();

		// random settings with a long output stall
		set_config($urandom_range(255), $urandom_range(32767));
		hold_at = accepted_reqs + 10;
		push_traffic(100);
		wait_idle();

		set_config($urandom_range(255), $urandom_range(32767));
		calm = 1'b1;
		push_traffic(80);
		wait_idle();

		repeat (40) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0)
			$display("rtp_receive_sequence_tracker verification clean");
		else
			$display("rtp_receive_sequence_tracker verification failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("rtp_receive_sequence_tracker verification failed");
		$finish;
	end

endmodule

`default_nettype wire
